### sv/rtc_pkg.sv
`timescale 1ns / 1ps
package rtc_pkg;

  // Edge and offset components are differences of two 32-bit values.
  localparam int SHORT_W  = 33;
  // Accumulator holds the exact determinant-scaled sums (up to 102 bits).
  localparam int ACC_W    = 104;
  // Multiplicand width: covers the cross-product vectors p and q.
  localparam int AOP_W    = 68;
  localparam int DIG_W    = 9;
  localparam int PP_W     = AOP_W + DIG_W;
  localparam int DIV_W    = ACC_W + 32;
  localparam int DIST_W   = 31;
  localparam int NUM_UOPS = 24;
  localparam int NUM_RES  = 10;
  localparam int QDEPTH   = 2;

  // Smallest accepted determinant magnitude, 4295 in Q32.32 scaled by 2^16.
  localparam logic signed [ACC_W-1:0] DET_MIN = ACC_W'(4295 * 65536);

  typedef logic signed [SHORT_W-1:0] short_t;

  typedef struct packed {
    short_t e1x, e1y, e1z;
    short_t e2x, e2y, e2z;
    short_t tx, ty, tz;
    logic   last;
  } tri_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DIST_W-1:0] tdist;
    logic              last;
  } res_t;

  // Operand sources of the shared multiplier.
  localparam logic [4:0] SRC_DX  = 5'd0;
  localparam logic [4:0] SRC_DY  = 5'd1;
  localparam logic [4:0] SRC_DZ  = 5'd2;
  localparam logic [4:0] SRC_E1X = 5'd3;
  localparam logic [4:0] SRC_E1Y = 5'd4;
  localparam logic [4:0] SRC_E1Z = 5'd5;
  localparam logic [4:0] SRC_E2X = 5'd6;
  localparam logic [4:0] SRC_E2Y = 5'd7;
  localparam logic [4:0] SRC_E2Z = 5'd8;
  localparam logic [4:0] SRC_TX  = 5'd9;
  localparam logic [4:0] SRC_TY  = 5'd10;
  localparam logic [4:0] SRC_TZ  = 5'd11;
  localparam logic [4:0] SRC_PX  = 5'd12;
  localparam logic [4:0] SRC_PY  = 5'd13;
  localparam logic [4:0] SRC_PZ  = 5'd14;
  localparam logic [4:0] SRC_QX  = 5'd15;
  localparam logic [4:0] SRC_QY  = 5'd16;
  localparam logic [4:0] SRC_QZ  = 5'd17;

  // Result register slots.
  localparam logic [3:0] R_PX   = 4'd0;
  localparam logic [3:0] R_PY   = 4'd1;
  localparam logic [3:0] R_PZ   = 4'd2;
  localparam logic [3:0] R_QX   = 4'd3;
  localparam logic [3:0] R_QY   = 4'd4;
  localparam logic [3:0] R_QZ   = 4'd5;
  localparam logic [3:0] R_DET  = 4'd6;
  localparam logic [3:0] R_UN   = 4'd7;
  localparam logic [3:0] R_VN   = 4'd8;
  localparam logic [3:0] R_TN   = 4'd9;
  localparam logic [3:0] R_NONE = 4'd15;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic       neg;
    logic       first;
    logic [3:0] dst;
  } uop_t;

  function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic n,
                              input logic f, input logic [3:0] d);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.neg   = n;
    u.first = f;
    u.dst   = d;
    return u;
  endfunction

  // Product sequence: p = D x E2, det = p.E1, un = p.T, q = T x E1, vn = q.D, tn = q.E2.
  function automatic uop_t uop_rom(input logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = mk(SRC_DY, SRC_E2Z, 1'b0, 1'b1, R_NONE);
      5'd1:  u = mk(SRC_DZ, SRC_E2Y, 1'b1, 1'b0, R_PX);
      5'd2:  u = mk(SRC_DZ, SRC_E2X, 1'b0, 1'b1, R_NONE);
      5'd3:  u = mk(SRC_DX, SRC_E2Z, 1'b1, 1'b0, R_PY);
      5'd4:  u = mk(SRC_DX, SRC_E2Y, 1'b0, 1'b1, R_NONE);
      5'd5:  u = mk(SRC_DY, SRC_E2X, 1'b1, 1'b0, R_PZ);
      5'd6:  u = mk(SRC_PX, SRC_E1X, 1'b0, 1'b1, R_NONE);
      5'd7:  u = mk(SRC_PY, SRC_E1Y, 1'b0, 1'b0, R_NONE);
      5'd8:  u = mk(SRC_PZ, SRC_E1Z, 1'b0, 1'b0, R_DET);
      5'd9:  u = mk(SRC_PX, SRC_TX,  1'b0, 1'b1, R_NONE);
      5'd10: u = mk(SRC_PY, SRC_TY,  1'b0, 1'b0, R_NONE);
      5'd11: u = mk(SRC_PZ, SRC_TZ,  1'b0, 1'b0, R_UN);
      5'd12: u = mk(SRC_TY, SRC_E1Z, 1'b0, 1'b1, R_NONE);
      5'd13: u = mk(SRC_TZ, SRC_E1Y, 1'b1, 1'b0, R_QX);
      5'd14: u = mk(SRC_TZ, SRC_E1X, 1'b0, 1'b1, R_NONE);
      5'd15: u = mk(SRC_TX, SRC_E1Z, 1'b1, 1'b0, R_QY);
      5'd16: u = mk(SRC_TX, SRC_E1Y, 1'b0, 1'b1, R_NONE);
      5'd17: u = mk(SRC_TY, SRC_E1X, 1'b1, 1'b0, R_QZ);
      5'd18: u = mk(SRC_QX, SRC_DX,  1'b0, 1'b1, R_NONE);
      5'd19: u = mk(SRC_QY, SRC_DY,  1'b0, 1'b0, R_NONE);
      5'd20: u = mk(SRC_QZ, SRC_DZ,  1'b0, 1'b0, R_VN);
      5'd21: u = mk(SRC_QX, SRC_E2X, 1'b0, 1'b1, R_NONE);
      5'd22: u = mk(SRC_QY, SRC_E2Y, 1'b0, 1'b0, R_NONE);
      5'd23: u = mk(SRC_QZ, SRC_E2Z, 1'b0, 1'b0, R_TN);
      default: u = mk(SRC_DX, SRC_DX, 1'b0, 1'b1, R_NONE);
    endcase
    return u;
  endfunction

endpackage

### sv/rtc_front.sv
`timescale 1ns / 1ps
module rtc_front import rtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] org_x_i,
  input  logic signed [31:0] org_y_i,
  input  logic signed [31:0] org_z_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic               last_tri_i,
  output logic               q_valid_o,
  output tri_t               q_data_o,
  input  logic               q_pop_i
);

  tri_t fifo_q [QDEPTH];
  tri_t wr_data;
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push_ok;

  // Edges and the origin offset are formed as the triangle comes in.
  always_comb begin
    wr_data.e1x  = SHORT_W'(b_x_i) - SHORT_W'(a_x_i);
    wr_data.e1y  = SHORT_W'(b_y_i) - SHORT_W'(a_y_i);
    wr_data.e1z  = SHORT_W'(b_z_i) - SHORT_W'(a_z_i);
    wr_data.e2x  = SHORT_W'(c_x_i) - SHORT_W'(a_x_i);
    wr_data.e2y  = SHORT_W'(c_y_i) - SHORT_W'(a_y_i);
    wr_data.e2z  = SHORT_W'(c_z_i) - SHORT_W'(a_z_i);
    wr_data.tx   = SHORT_W'(org_x_i) - SHORT_W'(a_x_i);
    wr_data.ty   = SHORT_W'(org_y_i) - SHORT_W'(a_y_i);
    wr_data.tz   = SHORT_W'(org_z_i) - SHORT_W'(a_z_i);
    wr_data.last = last_tri_i;
  end

  assign full      = (cnt_q == 2'(QDEPTH));
  assign push_ok   = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(q_pop_i);
    end
  end

endmodule

### sv/rtc_engine.sv
`timescale 1ns / 1ps
module rtc_engine import rtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               q_valid_i,
  input  tri_t               q_data_i,
  output logic               q_pop_o,
  output res_t               res_o,
  input  logic               res_ready_i
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_FLIP = 7'b0001000,
    ST_TEST = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  tri_t   tri_q;
  logic signed [ACC_W-1:0] res_q [NUM_RES];
  logic signed [ACC_W-1:0] prod_q, acc_q, uv_q;
  logic [4:0] step_q;
  logic [2:0] dig_q;
  logic [4:0] bit_q;
  logic [DIV_W-1:0] rem_q, dsh_q;
  logic [DIST_W-1:0] quo_q, dist_q;
  logic hit_q;

  uop_t uop;
  logic signed [AOP_W-1:0] a_op;
  short_t b_op;
  logic signed [39:0] b_ext;
  logic signed [DIG_W-1:0] dig;
  logic signed [PP_W-1:0] pp;
  logic signed [ACC_W-1:0] pp_ext, prod_next, acc_new;
  logic signed [ACC_W-1:0] det, un, vn, tn, uv_raw;
  logic flip, miss, sat, ge;
  logic [DIV_W-1:0] tn_sh, det31;

  assign uop = uop_rom(step_q);

  always_comb begin
    unique case (uop.a_sel)
      SRC_DX:  a_op = AOP_W'(dir_x_i);
      SRC_DY:  a_op = AOP_W'(dir_y_i);
      SRC_DZ:  a_op = AOP_W'(dir_z_i);
      SRC_TX:  a_op = AOP_W'(tri_q.tx);
      SRC_TY:  a_op = AOP_W'(tri_q.ty);
      SRC_TZ:  a_op = AOP_W'(tri_q.tz);
      SRC_PX:  a_op = res_q[R_PX][AOP_W-1:0];
      SRC_PY:  a_op = res_q[R_PY][AOP_W-1:0];
      SRC_PZ:  a_op = res_q[R_PZ][AOP_W-1:0];
      SRC_QX:  a_op = res_q[R_QX][AOP_W-1:0];
      SRC_QY:  a_op = res_q[R_QY][AOP_W-1:0];
      SRC_QZ:  a_op = res_q[R_QZ][AOP_W-1:0];
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (uop.b_sel)
      SRC_DX:  b_op = SHORT_W'(dir_x_i);
      SRC_DY:  b_op = SHORT_W'(dir_y_i);
      SRC_DZ:  b_op = SHORT_W'(dir_z_i);
      SRC_E1X: b_op = tri_q.e1x;
      SRC_E1Y: b_op = tri_q.e1y;
      SRC_E1Z: b_op = tri_q.e1z;
      SRC_E2X: b_op = tri_q.e2x;
      SRC_E2Y: b_op = tri_q.e2y;
      SRC_E2Z: b_op = tri_q.e2z;
      SRC_TX:  b_op = tri_q.tx;
      SRC_TY:  b_op = tri_q.ty;
      SRC_TZ:  b_op = tri_q.tz;
      default: b_op = '0;
    endcase
  end

  // The multiplier operand is consumed one byte per cycle, top (signed) byte first.
  always_comb begin
    b_ext = 40'(b_op);
    if (dig_q == 3'd4) begin
      dig = {b_ext[39], b_ext[39:32]};
    end else begin
      dig = {1'b0, b_ext[{dig_q[1:0], 3'b000} +: 8]};
    end
    pp        = PP_W'(a_op) * PP_W'(dig);
    pp_ext    = ACC_W'(pp);
    prod_next = (dig_q == 3'd4) ? pp_ext : ((prod_q <<< 8) + pp_ext);
    acc_new   = (uop.first ? '0 : acc_q) + (uop.neg ? -prod_q : prod_q);
  end

  always_comb begin
    det    = res_q[R_DET];
    un     = res_q[R_UN];
    vn     = res_q[R_VN];
    tn     = res_q[R_TN];
    flip   = det[ACC_W-1];
    uv_raw = un + vn;
    miss   = (det < DET_MIN) || (un < 0) || (det < un) || (vn < 0) ||
             (det < uv_q) || (tn < 0);
    tn_sh  = DIV_W'({tn, 16'b0});
    det31  = DIV_W'({det, 31'b0});
    sat    = (tn_sh >= det31);
    ge     = (rem_q >= dsh_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_MUL;
      ST_MUL:  if (dig_q == 3'd0) state_d = ST_ACC;
      ST_ACC:  state_d = (step_q == 5'(NUM_UOPS - 1)) ? ST_FLIP : ST_MUL;
      ST_FLIP: state_d = ST_TEST;
      ST_TEST: state_d = (miss || sat) ? ST_DONE : ST_DIV;
      ST_DIV:  if (bit_q == 5'd30) state_d = ST_DONE;
      ST_DONE: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.hit   = hit_q;
  assign res_o.tdist = dist_q;
  assign res_o.last  = tri_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        tri_q  <= q_data_i;
        step_q <= 5'd0;
        dig_q  <= 3'd4;
      end
      ST_MUL: begin
        prod_q <= prod_next;
        if (dig_q != 3'd0) dig_q <= dig_q - 3'd1;
      end
      ST_ACC: begin
        acc_q <= acc_new;
        if (uop.dst != R_NONE) res_q[uop.dst] <= acc_new;
        step_q <= step_q + 5'd1;
        dig_q  <= 3'd4;
      end
      ST_FLIP: begin
        res_q[R_DET] <= flip ? -det : det;
        res_q[R_UN]  <= flip ? -un : un;
        res_q[R_VN]  <= flip ? -vn : vn;
        res_q[R_TN]  <= flip ? -tn : tn;
        uv_q         <= flip ? -uv_raw : uv_raw;
      end
      ST_TEST: begin
        hit_q  <= !miss;
        dist_q <= miss ? '0 : '1;
        rem_q  <= tn_sh;
        dsh_q  <= det31 >> 1;
        bit_q  <= 5'd0;
        quo_q  <= '0;
      end
      ST_DIV: begin
        if (ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[DIST_W-2:0], ge};
        bit_q <= bit_q + 5'd1;
        if (bit_q == 5'd30) dist_q <= {quo_q[DIST_W-2:0], ge};
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  ap_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (dig_q <= 3'd4))
    else $error("digit counter out of range");

  ap_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_MUL) && (step_q == 5'd0) && (dig_q == 3'd4))
    else $error("pop did not start the product sequence");

  ap_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (res_q[R_DET] >= DET_MIN))
    else $error("division entered with a small determinant");

  ap_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.hit) |-> (res_o.tdist == '0))
    else $error("miss with nonzero distance");

endmodule

### sv/rtc_best.sv
`timescale 1ns / 1ps
module rtc_best import rtc_pkg::*; #(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  res_t              res_i,
  output logic              res_ready_o,
  output logic              empty,
  input  logic              pop,
  output logic              tri_hit_o,
  output logic [DIST_W-1:0] tri_dist_o,
  output logic              any_hit_o,
  output logic [DIST_W-1:0] near_dist_o,
  output logic [15:0]       near_index_o,
  output logic              run_end_o
);

  localparam int CW = $clog2(MAX_TRIANGLES);
  localparam int PW = (CW > 16) ? CW : 16;

  logic          out_valid_q;
  logic [31:0]   best_dist_q, nb_dist;
  logic          best_valid_q, nb_valid;
  logic [CW-1:0] best_pos_q, nb_pos, count_q;
  logic          take, upd;
  logic [PW-1:0] pos_ext;

  assign take        = res_i.valid && (!out_valid_q || pop);
  assign res_ready_o = take;
  assign empty       = !out_valid_q;

  always_comb begin
    upd      = res_i.hit && ({1'b0, res_i.tdist} < best_dist_q);
    nb_dist  = upd ? {1'b0, res_i.tdist} : best_dist_q;
    nb_valid = best_valid_q || upd;
    nb_pos   = upd ? count_q : best_pos_q;
    pos_ext  = PW'(nb_pos);
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tri_hit_o    <= res_i.hit;
      tri_dist_o   <= res_i.hit ? res_i.tdist : '0;
      any_hit_o    <= nb_valid;
      near_dist_o  <= nb_valid ? nb_dist[DIST_W-1:0] : '0;
      near_index_o <= nb_valid ? pos_ext[15:0] : 16'd0;
      run_end_o    <= res_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      best_dist_q  <= '1;
      best_valid_q <= 1'b0;
      best_pos_q   <= '0;
      count_q      <= '0;
    end else begin
      if (take) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
      if (take) begin
        if (res_i.last) begin
          best_dist_q  <= '1;
          best_valid_q <= 1'b0;
          best_pos_q   <= '0;
          count_q      <= '0;
        end else begin
          best_dist_q  <= nb_dist;
          best_valid_q <= nb_valid;
          best_pos_q   <= nb_pos;
          count_q      <= (count_q == CW'(MAX_TRIANGLES - 1)) ? '0 : count_q + 1'b1;
        end
      end
    end
  end

endmodule

### sv/ray_triangle_closest_hit.sv
`timescale 1ns / 1ps
// Closest-hit ray/triangle picker using the Moller-Trumbore test in exact fixed point.
// The ray (origin and direction, signed Q16.16) is written through the configuration
// port; the user must write it only while the block is idle, which the block does not
// enforce. Triangles are then pushed one per transaction and each produces one result
// transaction with its own hit and distance plus the running closest hit of the current
// pick, which is cleared after the triangle flagged last_tri_i. The front end forms the
// edges and origin offset on push and holds up to two triangles in a queue, so pushes
// are taken while the back end is busy. The back end runs all 24 exact products on a
// single shared 68x9-bit multiplier, one byte of the multiplier operand per cycle with
// an accumulation step after each product, then a restoring divider that yields one
// quotient bit per cycle. A triangle holds the back end for all products and the test
// when it misses or its distance saturates, and for the division too when the distance
// is divided out; the multiplier loop sets the sustained rate. A finished result sits in
// an output register until popped, and the next triangle proceeds behind it.
module ray_triangle_closest_hit import rtc_pkg::*; #(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic              last_tri_i,
  output logic              empty,
  input  logic              pop,
  output logic              tri_hit_o,
  output logic [30:0]       tri_dist_o,
  output logic              any_hit_o,
  output logic [30:0]       near_dist_o,
  output logic [15:0]       near_index_o,
  output logic              run_end_o
);

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;

  // Register writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      dir_x_q    <= '0;
      dir_y_q    <= '0;
      dir_z_q    <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        REG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        REG_DIR_X:    dir_x_q    <= cfg_data_i;
        REG_DIR_Y:    dir_y_q    <= cfg_data_i;
        REG_DIR_Z:    dir_z_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic q_valid, q_pop, res_ready;
  tri_t q_data;
  res_t res;

  rtc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .org_x_i    (origin_x_q),
    .org_y_i    (origin_y_q),
    .org_z_i    (origin_z_q),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .a_z_i      (a_z_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .b_z_i      (b_z_i),
    .c_x_i      (c_x_i),
    .c_y_i      (c_y_i),
    .c_z_i      (c_z_i),
    .last_tri_i (last_tri_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  rtc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_x_i     (dir_x_q),
    .dir_y_i     (dir_y_q),
    .dir_z_i     (dir_z_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  rtc_best #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .res_ready_o  (res_ready),
    .empty        (empty),
    .pop          (pop),
    .tri_hit_o    (tri_hit_o),
    .tri_dist_o   (tri_dist_o),
    .any_hit_o    (any_hit_o),
    .near_dist_o  (near_dist_o),
    .near_index_o (near_index_o),
    .run_end_o    (run_end_o)
  );

endmodule
